// ===== design/schnorr_proof_verifier_assert.svh =====
// Assertion helpers for the Schnorr proof verifier checker.
`ifndef SCHNORR_PROOF_VERIFIER_ASSERT_SVH
`define SCHNORR_PROOF_VERIFIER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SVP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("schnorr_proof_verifier: port check failed");

// Next-cycle implication, disabled during reset
`define SVP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("schnorr_proof_verifier: port check failed");

`endif

// ===== design/svp_pkg.sv =====
`default_nettype none

package svp_pkg;

   // Default word width of keys, operands and registers
   localparam int WORD_BITS_DEFAULT = 32;

   // Register index width and register map
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODULUS      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GENERATOR    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXPECTED_KEY = 2'd2;

   // Register reset values
   localparam int MODULUS_RESET      = 2;
   localparam int GENERATOR_RESET    = 2;
   localparam int EXPECTED_KEY_RESET = 0;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_KEY  = 2'd1,
      STATUS_CHAL = 2'd2,
      STATUS_EQ   = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== design/svp_if.sv =====
`default_nettype none

// Proof item channel
interface svp_req_if #(
   parameter int WORD_BITS = svp_pkg::WORD_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] public_key;
   logic [WORD_BITS-1:0] commitment;
   logic [WORD_BITS-1:0] challenge;
   logic [WORD_BITS-1:0] response;
   logic                 challenge_ok;

   modport source (
      output valid, public_key, commitment, challenge, response, challenge_ok,
      input  ready
   );
   modport sink (
      input  valid, public_key, commitment, challenge, response, challenge_ok,
      output ready
   );
endinterface

// Verdict channel
interface svp_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  valid_res;
   svp_pkg::status_type   status;

   modport source (output valid, valid_res, status, input ready);
   modport sink   (input valid, valid_res, status, output ready);
endinterface

// Register write channel
interface svp_csr_if #(
   parameter int WORD_BITS = svp_pkg::WORD_BITS_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic [svp_pkg::CSR_IDX_BITS-1:0]  index;
   logic [WORD_BITS-1:0]              data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/schnorr_proof_verifier.sv =====
// Schnorr proof verifier.
// req_ch carries one proof per item: public_key, commitment, challenge,
// response and the challenge_ok flag from the external hash unit. rsp_ch
// returns one verdict per item: valid_res and status (ok, key mismatch,
// challenge mismatch, equation failed). csr_ch writes modulus, generator
// and expected_key (index 0, 1, 2); write only while no item is in flight.
// Key mismatch, clear flag and modulus below two go straight to ST_POST,
// which hands the verdict to the output register. A full check compares
// g^response with commitment * public_key^challenge (mod m) on one shared
// bit-serial modular multiplier, one multiplier bit per cycle, one item at
// a time, squaring and multiplying over the exponent bits MSB first.
// The verdict sits in an output register; the next item is accepted while
// it waits, and a stalled rsp_ch only holds back the following verdict.
// Reset (synchronous, active high) returns the registers to modulus 2,
// generator 2, expected_key 0 and drops any item in flight.
`default_nettype none

module schnorr_proof_verifier #(
   parameter int WORD_BITS = svp_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   svp_req_if.sink    req_ch,
   svp_rsp_if.source  rsp_ch,
   svp_csr_if.sink    csr_ch
);

   localparam int                  CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);
   localparam logic [WORD_BITS-1:0] ONE_W   = WORD_BITS'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_G,
      ST_SQR_G,
      ST_MUL_G,
      ST_RED_Y,
      ST_SQR_Y,
      ST_MUL_Y,
      ST_RED_T,
      ST_FIN,
      ST_POST
   } state_type;

   // One multiplier bit: r = 2r + bit*a mod m, for r, a < m
   function automatic logic [WORD_BITS-1:0] mod_step(
      input logic [WORD_BITS-1:0] r,
      input logic                 bit_in,
      input logic [WORD_BITS-1:0] a,
      input logic [WORD_BITS-1:0] m
   );
      logic [WORD_BITS:0]   dbl;
      logic [WORD_BITS:0]   sum;
      logic [WORD_BITS-1:0] d;
      dbl = {r, 1'b0};
      d = (dbl >= {1'b0, m}) ? WORD_BITS'(dbl - {1'b0, m}) : dbl[WORD_BITS-1:0];
      sum = {1'b0, d} + {1'b0, a};
      if (bit_in) begin
         mod_step = (sum >= {1'b0, m}) ? WORD_BITS'(sum - {1'b0, m}) : sum[WORD_BITS-1:0];
      end else begin
         mod_step = d;
      end
   endfunction

   // Control and registered outputs
   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_valid_res_ff, rsp_valid_res_in;
   svp_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic [WORD_BITS-1:0] generator_ff, generator_in;
   logic [WORD_BITS-1:0] expected_key_ff, expected_key_in;

   // Datapath
   logic [WORD_BITS-1:0] r_ff, r_in;        // product accumulator
   logic [WORD_BITS-1:0] a_ff, a_in;        // multiplicand
   logic [WORD_BITS-1:0] b_ff, b_in;        // multiplier, shifted out MSB first
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;    // multiplier bit count
   logic [WORD_BITS-1:0] e_ff, e_in;        // exponent, shifted out MSB first
   logic [CNT_BITS-1:0]  ecnt_ff, ecnt_in;  // exponent bit count
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] left_ff, left_in;
   logic [WORD_BITS-1:0] right_ff, right_in;
   logic [WORD_BITS-1:0] y_ff, y_in;
   logic [WORD_BITS-1:0] t_ff, t_in;
   logic [WORD_BITS-1:0] c_ff, c_in;
   svp_pkg::status_type  status_ff, status_in;

   logic [WORD_BITS-1:0] step_res;
   logic                 op_last;
   logic                 exp_last;
   logic                 slot_free;
   logic                 req_take;
   logic                 csr_take;
   logic                 pow_g;

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.valid_res = rsp_valid_res_ff;
   assign rsp_ch.status    = rsp_status_ff;

   assign req_take  = req_ch.valid && req_ch.ready;
   assign csr_take  = csr_ch.valid && csr_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign step_res  = mod_step(r_ff, b_ff[WORD_BITS-1], a_ff, modulus_ff);
   assign op_last   = (cnt_ff == CNT_LAST);
   assign exp_last  = (ecnt_ff == CNT_LAST);
   assign pow_g     = (state_ff == ST_SQR_G) || (state_ff == ST_MUL_G);

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_valid_res_in = rsp_valid_res_ff;
      rsp_status_in    = rsp_status_ff;
      modulus_in       = modulus_ff;
      generator_in     = generator_ff;
      expected_key_in  = expected_key_ff;
      r_in             = step_res;
      a_in             = a_ff;
      b_in             = b_ff << 1;
      cnt_in           = cnt_ff + CNT_BITS'(1);
      e_in             = e_ff;
      ecnt_in          = ecnt_ff;
      base_in          = base_ff;
      left_in          = left_ff;
      right_in         = right_ff;
      y_in             = y_ff;
      t_in             = t_ff;
      c_in             = c_ff;
      status_in        = status_ff;

      // Register writes
      if (csr_take) begin
         unique case (csr_ch.index)
            svp_pkg::CSR_MODULUS:      modulus_in      = csr_ch.data;
            svp_pkg::CSR_GENERATOR:    generator_in    = csr_ch.data;
            svp_pkg::CSR_EXPECTED_KEY: expected_key_in = csr_ch.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               y_in = req_ch.public_key;
               t_in = req_ch.commitment;
               c_in = req_ch.challenge;
               e_in = req_ch.response;
               ecnt_in = '0;
               priority if (req_ch.public_key != expected_key_ff) begin
                  status_in = svp_pkg::STATUS_KEY;
                  state_in  = ST_POST;
               end else if (!req_ch.challenge_ok) begin
                  status_in = svp_pkg::STATUS_CHAL;
                  state_in  = ST_POST;
               end else if (modulus_ff < WORD_BITS'(2)) begin
                  status_in = svp_pkg::STATUS_EQ;
                  state_in  = ST_POST;
               end else begin
                  // g mod m
                  r_in     = '0;
                  cnt_in   = '0;
                  a_in     = ONE_W;
                  b_in     = generator_ff;
                  state_in = ST_RED_G;
               end
            end
         end

         ST_RED_G, ST_RED_Y: begin
            if (op_last) begin
               // base reduced; start the power with acc = 1
               base_in  = step_res;
               r_in     = '0;
               cnt_in   = '0;
               a_in     = ONE_W;
               b_in     = ONE_W;
               ecnt_in  = '0;
               if (state_ff == ST_RED_Y) begin
                  e_in     = c_ff;
                  state_in = ST_SQR_Y;
               end else begin
                  state_in = ST_SQR_G;
               end
            end
         end

         ST_SQR_G, ST_MUL_G, ST_SQR_Y, ST_MUL_Y: begin
            if (op_last) begin
               r_in   = '0;
               cnt_in = '0;
               priority if (((state_ff == ST_SQR_G) || (state_ff == ST_SQR_Y))
                            && e_ff[WORD_BITS-1]) begin
                  // exponent bit set: multiply by base
                  a_in     = step_res;
                  b_in     = base_ff;
                  state_in = pow_g ? ST_MUL_G : ST_MUL_Y;
               end else if (!exp_last) begin
                  // next exponent bit: square
                  e_in     = e_ff << 1;
                  ecnt_in  = ecnt_ff + CNT_BITS'(1);
                  a_in     = step_res;
                  b_in     = step_res;
                  state_in = pow_g ? ST_SQR_G : ST_SQR_Y;
               end else if (pow_g) begin
                  // g^s done; reduce y next
                  left_in  = step_res;
                  a_in     = ONE_W;
                  b_in     = y_ff;
                  state_in = ST_RED_Y;
               end else begin
                  // y^c done; reduce t next
                  right_in = step_res;
                  a_in     = ONE_W;
                  b_in     = t_ff;
                  state_in = ST_RED_T;
               end
            end
         end

         ST_RED_T: begin
            if (op_last) begin
               r_in     = '0;
               cnt_in   = '0;
               a_in     = step_res;
               b_in     = right_ff;
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            if (op_last) begin
               status_in = (step_res == left_ff) ? svp_pkg::STATUS_OK : svp_pkg::STATUS_EQ;
               state_in  = ST_POST;
            end
         end

         ST_POST: begin
            // hand the verdict to the output register
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_valid_res_in = (status_ff == svp_pkg::STATUS_OK);
               rsp_status_in    = status_ff;
               state_in         = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State, registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         modulus_ff      <= WORD_BITS'(svp_pkg::MODULUS_RESET);
         generator_ff    <= WORD_BITS'(svp_pkg::GENERATOR_RESET);
         expected_key_ff <= WORD_BITS'(svp_pkg::EXPECTED_KEY_RESET);
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         modulus_ff      <= modulus_in;
         generator_ff    <= generator_in;
         expected_key_ff <= expected_key_in;
      end
      rsp_valid_res_ff <= rsp_valid_res_in;
      rsp_status_ff    <= rsp_status_in;
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      cnt_ff    <= cnt_in;
      e_ff      <= e_in;
      ecnt_ff   <= ecnt_in;
      base_ff   <= base_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      y_ff      <= y_in;
      t_ff      <= t_in;
      c_ff      <= c_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire

// ===== design/svp_checker.sv =====
`default_nettype none

`include "schnorr_proof_verifier_assert.svh"

module svp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_valid_res,
   input wire logic [1:0] rsp_status
);

   logic       req_take;
   logic       rsp_take;
   logic       rsp_wait;
   logic [1:0] pending_ff, pending_in;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;

   // items accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `SVP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid)
   `SVP_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_wait, $stable({rsp_valid_res, rsp_status}))
   `SVP_ASSERT_NXT(a_one_at_a_time, clock, reset, req_take, !req_ready)
   `SVP_ASSERT_IMP(a_no_orphan, clock, reset, rsp_valid, (pending_ff != 2'd0) && (pending_ff != 2'd3))
   `SVP_ASSERT_IMP(a_verdict, clock, reset, rsp_valid, rsp_valid_res == (rsp_status == svp_pkg::STATUS_OK))

endmodule

bind schnorr_proof_verifier svp_checker u_svp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_valid_res (rsp_ch.valid_res),
   .rsp_status    (rsp_ch.status)
);

`default_nettype wire
